// ----- hw/rtl/bpc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types and helpers for the barometric pressure compensation block.
// ----------------------------------------------------------------------------
package bpc_pkg;

   // Register indexes on the CSR port (byte address = 8 * index)
   localparam logic [1:0] REG_COEF_A = 2'd0;
   localparam logic [1:0] REG_COEF_B = 2'd1;
   localparam logic [1:0] REG_COEF_C = 2'd2;
   localparam logic [1:0] REG_OSS    = 2'd3;

   localparam int DIV_STEPS = 32;

   typedef struct packed {
      logic [15:0] raw_temperature;
      logic [23:0] raw_pressure;
   } req_type;

   typedef struct packed {
      logic signed [15:0] temperature_tenths;
      logic signed [31:0] pressure_pascal;
      logic               divide_fault;
   } rsp_type;

   // Signed divide by 2^k, truncating toward zero
   function automatic logic signed [31:0] div_pow2(input logic signed [31:0] x,
                                                   input int unsigned k);
      logic signed [31:0] bias;
      bias = x[31] ? ((32'sd1 <<< k) - 32'sd1) : 32'sd0;
      return (x + bias) >>> k;
   endfunction

   // Sign-extend a 16-bit coefficient
   function automatic logic signed [31:0] sx16(input logic [15:0] v);
      return signed'({{16{v[15]}}, v});
   endfunction

endpackage

// ----- hw/rtl/barometric_pressure_compensation.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barometric_pressure_compensation
// Pipelined integer temperature / pressure compensation with two
// bit-per-stage dividers.
// ----------------------------------------------------------------------------
//  channel   ports          role
//  request   req_*          raw temperature and pressure in, valid/stall
//  response  rsp_*          compensated temperature, pressure, fault out
//  csr       csr_*          APB-style register port, 64-bit data
//
//  One transfer per cycle while the output is not stalled; the pipeline holds
//  the two 32-stage restoring dividers (temperature term and pressure quotient).
//  The whole pipeline advances together while the output register is empty
//  or being taken; a stalled output freezes every stage.
//  Synchronous reset clears valid bits and the coefficient and OSS registers.
// ----------------------------------------------------------------------------
module barometric_pressure_compensation
   import bpc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);

   // ---------------- configuration registers ----------------
   logic [63:0] coef_a_ff, coef_b_ff;
   logic [31:0] coef_c_ff;
   logic [1:0]  oss_ff;
   logic [1:0]  csr_index;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[4:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_a_ff <= '0;
         coef_b_ff <= '0;
         coef_c_ff <= '0;
         oss_ff    <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_index)
            REG_COEF_A: coef_a_ff <= csr_pwdata;
            REG_COEF_B: coef_b_ff <= csr_pwdata;
            REG_COEF_C: coef_c_ff <= csr_pwdata[31:0];
            REG_OSS:    oss_ff    <= csr_pwdata[1:0];
            default:    ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_COEF_A: csr_prdata = coef_a_ff;
         REG_COEF_B: csr_prdata = coef_b_ff;
         REG_COEF_C: csr_prdata = {32'd0, coef_c_ff};
         REG_OSS:    csr_prdata = {62'd0, oss_ff};
         default:    csr_prdata = '0;
      endcase
   end

   // coefficient fields
   logic signed [31:0] ac1, ac2, ac3, ac4, ac5, ac6, cb1, cb2, cmc, cmd;
   assign ac1 = sx16(coef_a_ff[63:48]);
   assign ac2 = sx16(coef_a_ff[47:32]);
   assign ac3 = sx16(coef_a_ff[31:16]);
   assign ac4 = signed'({16'd0, coef_a_ff[15:0]});
   assign ac5 = signed'({16'd0, coef_b_ff[63:48]});
   assign ac6 = signed'({16'd0, coef_b_ff[47:32]});
   assign cb1 = sx16(coef_b_ff[31:16]);
   assign cb2 = sx16(coef_b_ff[15:0]);
   assign cmc = sx16(coef_c_ff[31:16]);
   assign cmd = sx16(coef_c_ff[15:0]);

   // ---------------- pipeline control ----------------
   logic adv;
   logic rsp_valid_ff;
   rsp_type rsp_data_ff;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------- S1: temperature product, pressure shift ----------------
   logic               s1_v_ff;
   logic signed [31:0] s1_m_ff;
   logic [18:0]        s1_rp_ff;
   logic signed [31:0] s1_diff;
   logic [23:0]        s1_rp_full;

   assign s1_diff    = signed'({16'd0, req_data.raw_temperature}) - ac6;
   assign s1_rp_full = req_data.raw_pressure >> (4'd8 - {2'd0, oss_ff});

   always_ff @(posedge clock) begin
      if (reset) s1_v_ff <= 1'b0;
      else if (adv) s1_v_ff <= req_valid;
      if (adv) begin
         s1_m_ff  <= s1_diff * ac5;
         s1_rp_ff <= s1_rp_full[18:0];
      end
   end

   // ---------------- S2: divider operands for the temperature term ----------------
   logic               td_v_ff   [0:DIV_STEPS];
   logic [31:0]        td_num_ff [0:DIV_STEPS];
   logic [31:0]        td_rem_ff [0:DIV_STEPS];
   logic [31:0]        td_den_ff [0:DIV_STEPS];
   logic               td_neg_ff [0:DIV_STEPS];
   logic               td_flt_ff [0:DIV_STEPS];
   logic signed [31:0] td_ta_ff  [0:DIV_STEPS];
   logic [18:0]        td_rp_ff  [0:DIV_STEPS];

   logic signed [31:0] s2_ta, s2_den, s2_num;
   assign s2_ta  = div_pow2(s1_m_ff, 15);
   assign s2_den = s2_ta + cmd;
   assign s2_num = cmc <<< 11;

   // one quotient bit per stage
   logic [31:0] td_num_in [0:DIV_STEPS-1];
   logic [31:0] td_rem_in [0:DIV_STEPS-1];
   always_comb begin
      for (int k = 0; k < DIV_STEPS; k++) begin
         logic [32:0] cand;
         logic        ge;
         cand = {td_rem_ff[k], td_num_ff[k][31]};
         ge   = cand >= {1'b0, td_den_ff[k]};
         td_rem_in[k] = ge ? 32'(cand - {1'b0, td_den_ff[k]}) : cand[31:0];
         td_num_in[k] = {td_num_ff[k][30:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= DIV_STEPS; k++) td_v_ff[k] <= 1'b0;
      end else if (adv) begin
         td_v_ff[0] <= s1_v_ff;
         for (int k = 0; k < DIV_STEPS; k++) td_v_ff[k+1] <= td_v_ff[k];
      end
      if (adv) begin
         td_num_ff[0] <= s2_num[31] ? 32'(-s2_num) : 32'(s2_num);
         td_den_ff[0] <= s2_den[31] ? 32'(-s2_den) : 32'(s2_den);
         td_rem_ff[0] <= '0;
         td_neg_ff[0] <= s2_num[31] ^ s2_den[31];
         td_flt_ff[0] <= (s2_den == 32'sd0);
         td_ta_ff[0]  <= s2_ta;
         td_rp_ff[0]  <= s1_rp_ff;
         for (int k = 0; k < DIV_STEPS; k++) begin
            td_num_ff[k+1] <= td_num_in[k];
            td_rem_ff[k+1] <= td_rem_in[k];
            td_den_ff[k+1] <= td_den_ff[k];
            td_neg_ff[k+1] <= td_neg_ff[k];
            td_flt_ff[k+1] <= td_flt_ff[k];
            td_ta_ff[k+1]  <= td_ta_ff[k];
            td_rp_ff[k+1]  <= td_rp_ff[k];
         end
      end
   end

   // ---------------- SA: true temperature ----------------
   logic               sa_v_ff, sa_flt_ff;
   logic signed [31:0] sa_dev_ff;
   logic signed [15:0] sa_temp_ff;
   logic [18:0]        sa_rp_ff;
   logic signed [31:0] sa_tb, sa_tfine, sa_t;
   logic signed [15:0] sa_sat;

   assign sa_tb    = td_neg_ff[DIV_STEPS] ? signed'(-td_num_ff[DIV_STEPS])
                                          : signed'(td_num_ff[DIV_STEPS]);
   assign sa_tfine = td_ta_ff[DIV_STEPS] + sa_tb;
   assign sa_t     = div_pow2(sa_tfine + 32'sd8, 4);

   always_comb begin
      if (sa_t > 32'sd32767)       sa_sat = 16'sh7fff;
      else if (sa_t < -32'sd32768) sa_sat = 16'sh8000;
      else                         sa_sat = sa_t[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) sa_v_ff <= 1'b0;
      else if (adv) sa_v_ff <= td_v_ff[DIV_STEPS];
      if (adv) begin
         sa_flt_ff  <= td_flt_ff[DIV_STEPS];
         sa_dev_ff  <= sa_tfine - 32'sd4000;
         sa_temp_ff <= sa_sat;
         sa_rp_ff   <= td_rp_ff[DIV_STEPS];
      end
   end

   // ---------------- SB: products of the deviation ----------------
   logic               sb_v_ff, sb_flt_ff;
   logic signed [31:0] sb_sq_ff, sb_b_ff, sb_a3_ff;
   logic signed [15:0] sb_temp_ff;
   logic [18:0]        sb_rp_ff;

   always_ff @(posedge clock) begin
      if (reset) sb_v_ff <= 1'b0;
      else if (adv) sb_v_ff <= sa_v_ff;
      if (adv) begin
         sb_flt_ff  <= sa_flt_ff;
         sb_sq_ff   <= sa_dev_ff * sa_dev_ff;
         sb_b_ff    <= ac2 * sa_dev_ff;
         sb_a3_ff   <= ac3 * sa_dev_ff;
         sb_temp_ff <= sa_temp_ff;
         sb_rp_ff   <= sa_rp_ff;
      end
   end

   // ---------------- SC: scale down ----------------
   logic               sc_v_ff, sc_flt_ff;
   logic signed [31:0] sc_sq_ff, sc_pb_ff, sc_pa2_ff;
   logic signed [15:0] sc_temp_ff;
   logic [18:0]        sc_rp_ff;

   always_ff @(posedge clock) begin
      if (reset) sc_v_ff <= 1'b0;
      else if (adv) sc_v_ff <= sb_v_ff;
      if (adv) begin
         sc_flt_ff  <= sb_flt_ff;
         sc_sq_ff   <= div_pow2(sb_sq_ff, 12);
         sc_pb_ff   <= div_pow2(sb_b_ff, 11);
         sc_pa2_ff  <= div_pow2(sb_a3_ff, 13);
         sc_temp_ff <= sb_temp_ff;
         sc_rp_ff   <= sb_rp_ff;
      end
   end

   // ---------------- SD: products of the squared deviation ----------------
   logic               sd_v_ff, sd_flt_ff;
   logic signed [31:0] sd_ma_ff, sd_mb_ff, sd_pb_ff, sd_pa2_ff;
   logic signed [15:0] sd_temp_ff;
   logic [18:0]        sd_rp_ff;

   always_ff @(posedge clock) begin
      if (reset) sd_v_ff <= 1'b0;
      else if (adv) sd_v_ff <= sc_v_ff;
      if (adv) begin
         sd_flt_ff  <= sc_flt_ff;
         sd_ma_ff   <= cb2 * sc_sq_ff;
         sd_mb_ff   <= cb1 * sc_sq_ff;
         sd_pb_ff   <= sc_pb_ff;
         sd_pa2_ff  <= sc_pa2_ff;
         sd_temp_ff <= sc_temp_ff;
         sd_rp_ff   <= sc_rp_ff;
      end
   end

   // ---------------- SE: offset and scale terms ----------------
   logic               se_v_ff, se_flt_ff;
   logic signed [31:0] se_offp_ff, se_pc2_ff;
   logic signed [15:0] se_temp_ff;
   logic [18:0]        se_rp_ff;
   logic signed [31:0] se_pc, se_pb2;

   assign se_pc  = div_pow2(sd_ma_ff, 11) + sd_pb_ff;
   assign se_pb2 = div_pow2(sd_mb_ff, 16);

   always_ff @(posedge clock) begin
      if (reset) se_v_ff <= 1'b0;
      else if (adv) se_v_ff <= sd_v_ff;
      if (adv) begin
         se_flt_ff  <= sd_flt_ff;
         se_offp_ff <= (((ac1 <<< 2) + se_pc) <<< oss_ff) + 32'sd2;
         se_pc2_ff  <= div_pow2(sd_pa2_ff + se_pb2 + 32'sd2, 2);
         se_temp_ff <= sd_temp_ff;
         se_rp_ff   <= sd_rp_ff;
      end
   end

   // ---------------- SF: offset, scale product ----------------
   logic               sf_v_ff, sf_flt_ff;
   logic signed [31:0] sf_off_ff;
   logic [31:0]        sf_scm_ff;
   logic signed [15:0] sf_temp_ff;
   logic [18:0]        sf_rp_ff;
   logic [31:0]        sf_fac;

   assign sf_fac = 32'(se_pc2_ff + 32'sd32768);

   always_ff @(posedge clock) begin
      if (reset) sf_v_ff <= 1'b0;
      else if (adv) sf_v_ff <= se_v_ff;
      if (adv) begin
         sf_flt_ff  <= se_flt_ff;
         sf_off_ff  <= div_pow2(se_offp_ff, 2);
         sf_scm_ff  <= 32'(ac4) * sf_fac;
         sf_temp_ff <= se_temp_ff;
         sf_rp_ff   <= se_rp_ff;
      end
   end

   // ---------------- SG: dividend product ----------------
   logic               sg_v_ff, sg_flt_ff;
   logic [16:0]        sg_scale_ff;
   logic [31:0]        sg_prod_ff;
   logic signed [15:0] sg_temp_ff;
   logic [31:0]        sg_diff, sg_mul;

   assign sg_diff = {13'd0, sf_rp_ff} - 32'(sf_off_ff);
   assign sg_mul  = 32'd50000 >> oss_ff;

   always_ff @(posedge clock) begin
      if (reset) sg_v_ff <= 1'b0;
      else if (adv) sg_v_ff <= sf_v_ff;
      if (adv) begin
         sg_flt_ff   <= sf_flt_ff;
         sg_scale_ff <= sf_scm_ff[31:15];
         sg_prod_ff  <= sg_diff * sg_mul;
         sg_temp_ff  <= sf_temp_ff;
      end
   end

   // ---------------- pressure quotient divider ----------------
   logic               pd_v_ff   [0:DIV_STEPS];
   logic [31:0]        pd_num_ff [0:DIV_STEPS];
   logic [31:0]        pd_rem_ff [0:DIV_STEPS];
   logic [31:0]        pd_den_ff [0:DIV_STEPS];
   logic               pd_shq_ff [0:DIV_STEPS];
   logic               pd_flt_ff [0:DIV_STEPS];
   logic signed [15:0] pd_temp_ff[0:DIV_STEPS];

   logic [31:0] pd_num_in [0:DIV_STEPS-1];
   logic [31:0] pd_rem_in [0:DIV_STEPS-1];
   always_comb begin
      for (int k = 0; k < DIV_STEPS; k++) begin
         logic [32:0] cand;
         logic        ge;
         cand = {pd_rem_ff[k], pd_num_ff[k][31]};
         ge   = cand >= {1'b0, pd_den_ff[k]};
         pd_rem_in[k] = ge ? 32'(cand - {1'b0, pd_den_ff[k]}) : cand[31:0];
         pd_num_in[k] = {pd_num_ff[k][30:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= DIV_STEPS; k++) pd_v_ff[k] <= 1'b0;
      end else if (adv) begin
         pd_v_ff[0] <= sg_v_ff;
         for (int k = 0; k < DIV_STEPS; k++) pd_v_ff[k+1] <= pd_v_ff[k];
      end
      if (adv) begin
         // small products are doubled before the divide, large ones after
         pd_num_ff[0]  <= sg_prod_ff[31] ? sg_prod_ff : {sg_prod_ff[30:0], 1'b0};
         pd_shq_ff[0]  <= sg_prod_ff[31];
         pd_den_ff[0]  <= {15'd0, sg_scale_ff};
         pd_rem_ff[0]  <= '0;
         pd_flt_ff[0]  <= sg_flt_ff || (sg_scale_ff == 17'd0);
         pd_temp_ff[0] <= sg_temp_ff;
         for (int k = 0; k < DIV_STEPS; k++) begin
            pd_num_ff[k+1]  <= pd_num_in[k];
            pd_rem_ff[k+1]  <= pd_rem_in[k];
            pd_den_ff[k+1]  <= pd_den_ff[k];
            pd_shq_ff[k+1]  <= pd_shq_ff[k];
            pd_flt_ff[k+1]  <= pd_flt_ff[k];
            pd_temp_ff[k+1] <= pd_temp_ff[k];
         end
      end
   end

   // ---------------- SI: raw pressure ----------------
   logic               si_v_ff, si_flt_ff;
   logic signed [31:0] si_p_ff, si_x_ff;
   logic signed [15:0] si_temp_ff;
   logic signed [31:0] si_p;

   assign si_p = pd_shq_ff[DIV_STEPS] ? signed'({pd_num_ff[DIV_STEPS][30:0], 1'b0})
                                      : signed'(pd_num_ff[DIV_STEPS]);

   always_ff @(posedge clock) begin
      if (reset) si_v_ff <= 1'b0;
      else if (adv) si_v_ff <= pd_v_ff[DIV_STEPS];
      if (adv) begin
         si_flt_ff  <= pd_flt_ff[DIV_STEPS];
         si_p_ff    <= si_p;
         si_x_ff    <= div_pow2(si_p, 8);
         si_temp_ff <= pd_temp_ff[DIV_STEPS];
      end
   end

   // ---------------- SJ: correction products ----------------
   logic               sj_v_ff, sj_flt_ff;
   logic signed [31:0] sj_p_ff, sj_sqx_ff, sj_mb_ff;
   logic signed [15:0] sj_temp_ff;

   always_ff @(posedge clock) begin
      if (reset) sj_v_ff <= 1'b0;
      else if (adv) sj_v_ff <= si_v_ff;
      if (adv) begin
         sj_flt_ff  <= si_flt_ff;
         sj_p_ff    <= si_p_ff;
         sj_sqx_ff  <= si_x_ff * si_x_ff;
         sj_mb_ff   <= -32'sd7357 * si_p_ff;
         sj_temp_ff <= si_temp_ff;
      end
   end

   // ---------------- SK: second correction product ----------------
   logic               sk_v_ff, sk_flt_ff;
   logic signed [31:0] sk_p_ff, sk_ma_ff, sk_pb_ff;
   logic signed [15:0] sk_temp_ff;

   always_ff @(posedge clock) begin
      if (reset) sk_v_ff <= 1'b0;
      else if (adv) sk_v_ff <= sj_v_ff;
      if (adv) begin
         sk_flt_ff  <= sj_flt_ff;
         sk_p_ff    <= sj_p_ff;
         sk_ma_ff   <= sj_sqx_ff * 32'sd3038;
         sk_pb_ff   <= div_pow2(sj_mb_ff, 16);
         sk_temp_ff <= sj_temp_ff;
      end
   end

   // ---------------- output register ----------------
   logic signed [31:0] out_corr;
   assign out_corr = div_pow2(div_pow2(sk_ma_ff, 16) + sk_pb_ff + 32'sd3791, 4);

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (adv) rsp_valid_ff <= sk_v_ff;
      if (adv) begin
         rsp_data_ff.divide_fault       <= sk_flt_ff;
         rsp_data_ff.temperature_tenths <= sk_flt_ff ? 16'sd0 : sk_temp_ff;
         rsp_data_ff.pressure_pascal    <= sk_flt_ff ? 32'sd0 : sk_p_ff + out_corr;
      end
   end

endmodule
